[hdl/tks_pkg.sv]
// Shared types and constants for the top-k sum tracker.
package tks_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KIND_W       = 2;
    localparam int SLOT_W       = 10;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 11;
    localparam int SUM_W        = 42;

    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // one word of the entry table
    typedef struct packed {
        logic             active;
        logic             in_top;
        logic [VAL_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/tks_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/top_k_sum_tracker_core.sv]
// Top level of the top-k sum tracker: sequencer around one entry-table RAM.
//
//  channel | signals                          | direction | beat carries
//  --------+----------------------------------+-----------+---------------------------
//  cfg     | cfg_valid cfg_ready top_count    | in        | k, number of values summed
//  in      | in_valid in_ready kind slot value| in        | remove / insert / clear
//  out     | out_valid out_ready top_sum      | out       | running top sum and best
//          | best_sum                         |           |
//
//  Steps per beat, accept to result register:
//    no-op, insert with room, remove from the rest: CHECK then DONE; slot beyond CAPACITY: DONE.
//    insert into a full group, remove from the top group: CHECK, SCAN, TAIL, DECIDE, DONE, plus
//    a WR2 write when the group minimum is displaced; one table scan, one entry per cycle.
//    clear: a CLEAR sweep over the RAM write port, then DONE.
//  Reset: a clearing pass over every entry runs first; in_ready stays low meanwhile.
//  Stalls: a held output beat only blocks the final step of the next item; the next
//  item is accepted and worked on while the result waits. cfg_ready is always high.
module top_k_sum_tracker_core
    import tks_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  top_count,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [SLOT_W-1:0] slot,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUM_W-1:0]  top_sum,
    output logic [SUM_W-1:0]  best_sum
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_TAIL   = 8'b0001_0000,
        S_DECIDE = 8'b0010_0000,
        S_WR2    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    // control state
    state_t             state_reg,       state_next;
    logic [AW-1:0]      addr_reg,        addr_next;
    logic               clr_item_reg,    clr_item_next;
    logic [CNT_W-1:0]   top_count_reg,   top_count_next;
    logic [CNT_W-1:0]   top_entries_reg, top_entries_next;
    logic [SUM_W-1:0]   sum_reg,         sum_next;
    logic [SUM_W-1:0]   best_reg,        best_next;
    logic               out_valid_reg,   out_valid_next;
    logic               scan_vld_reg,    scan_vld_next;
    logic               found_reg,       found_next;

    // payload
    logic [AW-1:0]      slot_reg,        slot_next;
    logic [VAL_W-1:0]   value_reg,       value_next;
    logic               ins_reg,         ins_next;
    logic               scan_max_reg,    scan_max_next;
    logic [AW-1:0]      scan_idx_reg,    scan_idx_next;
    logic [AW-1:0]      pick_addr_reg,   pick_addr_next;
    logic [VAL_W-1:0]   pick_val_reg,    pick_val_next;
    logic [SUM_W-1:0]   out_top_reg,     out_top_next;
    logic [SUM_W-1:0]   out_best_reg,    out_best_next;

    // RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic               slot_ok;
    logic               cand;
    logic               take;
    logic [SUM_W-1:0]   best_new;

    assign rd_entry = ram_rdata;
    assign slot_ok  = 32'(slot) < 32'(CAPACITY);
    assign best_new = (sum_reg > best_reg) ? sum_reg : best_reg;

    // scan candidate: top min (insert) or rest max (remove); ties pick lowest / highest slot
    assign cand = rd_entry.active && (scan_max_reg ? !rd_entry.in_top : rd_entry.in_top);
    assign take = cand && (!found_reg ||
                  (scan_max_reg ? (rd_entry.val >= pick_val_reg)
                                : (rd_entry.val < pick_val_reg)));

    tks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign top_sum   = out_top_reg;
    assign best_sum  = out_best_reg;

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        clr_item_next    = clr_item_reg;
        top_count_next   = cfg_valid ? top_count : top_count_reg;
        top_entries_next = top_entries_reg;
        sum_next         = sum_reg;
        best_next        = best_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        slot_next        = slot_reg;
        value_next       = value_reg;
        ins_next         = ins_reg;
        scan_max_next    = scan_max_reg;
        pick_addr_next   = pick_addr_reg;
        pick_val_next    = pick_val_reg;
        out_top_next     = out_top_reg;
        out_best_next    = out_best_reg;
        scan_vld_next    = (state_reg == S_SCAN);
        scan_idx_next    = addr_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep: one entry per cycle back to inactive
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = clr_item_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                // look up the slot while the beat is taken
                ram_raddr = AW'(slot);
                if (in_valid)
                begin
                    slot_next  = AW'(slot);
                    value_next = value;
                    ins_next   = (kind == KIND_INSERT);
                    if (kind >= KIND_CLEAR)
                    begin
                        addr_next        = '0;
                        clr_item_next    = 1'b1;
                        top_entries_next = '0;
                        sum_next         = '0;
                        best_next        = '0;
                        state_next       = S_CLEAR;
                    end
                    else if (!slot_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                addr_next  = '0;
                found_next = 1'b0;
                state_next = S_DONE;
                if (ins_reg)
                begin
                    scan_max_next = 1'b0;
                    if (!rd_entry.active)
                    begin
                        if (top_entries_reg < top_count_reg)
                        begin
                            ram_we           = 1'b1;
                            ram_wdata        = '{active: 1'b1, in_top: 1'b1, val: value_reg};
                            top_entries_next = top_entries_reg + 1'b1;
                            sum_next         = sum_reg + SUM_W'(value_reg);
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
                else
                begin
                    scan_max_next = 1'b1;
                    if (rd_entry.active)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '{active: 1'b0, in_top: 1'b0, val: rd_entry.val};
                        if (rd_entry.in_top)
                        begin
                            top_entries_next = top_entries_reg - 1'b1;
                            sum_next         = sum_reg - SUM_W'(rd_entry.val);
                            state_next       = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                ram_raddr = addr_reg;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (!scan_max_reg)
                begin
                    if (found_reg && (value_reg > pick_val_reg))
                    begin
                        // demote the group minimum, new entry joins the group next
                        ram_we     = 1'b1;
                        ram_waddr  = pick_addr_reg;
                        ram_wdata  = '{active: 1'b1, in_top: 1'b0, val: pick_val_reg};
                        sum_next   = sum_reg - SUM_W'(pick_val_reg) + SUM_W'(value_reg);
                        state_next = S_WR2;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '{active: 1'b1, in_top: 1'b0, val: value_reg};
                    end
                end
                else if (found_reg)
                begin
                    // promote the largest of the rest
                    ram_we           = 1'b1;
                    ram_waddr        = pick_addr_reg;
                    ram_wdata        = '{active: 1'b1, in_top: 1'b1, val: pick_val_reg};
                    top_entries_next = top_entries_reg + 1'b1;
                    sum_next         = sum_reg + SUM_W'(pick_val_reg);
                end
            end
            S_WR2:
            begin
                ram_we     = 1'b1;
                ram_wdata  = '{active: 1'b1, in_top: 1'b1, val: value_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    best_next      = best_new;
                    out_top_next   = sum_reg;
                    out_best_next  = best_new;
                    out_valid_next = 1'b1;
                    clr_item_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // scan compare, in the cycle after the read address was given
        if (scan_vld_reg && take)
        begin
            found_next     = 1'b1;
            pick_addr_next = scan_idx_reg;
            pick_val_next  = rd_entry.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            addr_reg        <= '0;
            clr_item_reg    <= 1'b0;
            top_count_reg   <= CNT_W'(1);
            top_entries_reg <= '0;
            sum_reg         <= '0;
            best_reg        <= '0;
            out_valid_reg   <= 1'b0;
            scan_vld_reg    <= 1'b0;
            found_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            clr_item_reg    <= clr_item_next;
            top_count_reg   <= top_count_next;
            top_entries_reg <= top_entries_next;
            sum_reg         <= sum_next;
            best_reg        <= best_next;
            out_valid_reg   <= out_valid_next;
            scan_vld_reg    <= scan_vld_next;
            found_reg       <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        value_reg     <= value_next;
        ins_reg       <= ins_next;
        scan_max_reg  <= scan_max_next;
        scan_idx_reg  <= scan_idx_next;
        pick_addr_reg <= pick_addr_next;
        pick_val_reg  <= pick_val_next;
        out_top_reg   <= out_top_next;
        out_best_reg  <= out_best_next;
    end

    // best never trails the sum it was built from
    a_best_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_sum >= top_sum))
        else $error("best_sum below top_sum");

    // no item may enter during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("input ready during clear sweep");

    // the table is never written while scanning
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("table write during scan");

    // compare data always belongs to a scan read
    a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        scan_vld_reg |-> $past(state_reg == S_SCAN))
        else $error("scan compare without scan read");

endmodule
